/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion clocked on clk, disabled while rst is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Assertion clocked on clk, also checked during reset.
`define ASSERT_CLK(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

/* hw/rtl/ggc_pkg.sv */
// ----------------------------------------------------------------------------
// ggc_pkg
// Shared types, codes and tables of the go-to-goal controller.
// ----------------------------------------------------------------------------
`default_nettype none

package ggc_pkg;

   localparam int CORDIC_ITERATIONS = 16;
   localparam int TableLen          = 24;
   localparam int CordicSteps       = (CORDIC_ITERATIONS > TableLen) ? TableLen
                                                                     : CORDIC_ITERATIONS;
   localparam int IterW             = (CordicSteps > 1) ? $clog2(CordicSteps) : 1;

   localparam int VecW = 36;   // CORDIC vector datapath
   localparam int AngW = 24;   // angles in Q.20

   localparam logic signed [AngW-1:0] PiQ20 = 24'sd3294199;
   localparam logic signed [32:0] InvGainQ30 = 33'sd652032874;

   typedef enum logic [1:0] {
      KindNone   = 2'd0,
      KindCmd    = 2'd1,
      KindDone   = 2'd2,
      KindReset  = 2'd3
   } kind_type;

   localparam logic OpSample = 1'b0;
   localparam logic OpGoal   = 1'b1;

   localparam logic [1:0] CsrAngleDeadband    = 2'd0;
   localparam logic [1:0] CsrDistanceDeadband = 2'd1;
   localparam logic [1:0] CsrAngleGain        = 2'd2;
   localparam logic [1:0] CsrLinearGain       = 2'd3;

   typedef struct packed {
      logic                   start;
      logic signed [VecW-1:0] x;
      logic signed [VecW-1:0] y;
   } cordic_req_type;

   typedef struct packed {
      logic                   done;
      logic signed [AngW-1:0] ang;
      logic signed [VecW-1:0] mag;
   } cordic_rsp_type;

   function automatic logic signed [AngW-1:0] atan_q20(input logic [4:0] idx);
      logic signed [AngW-1:0] r;
      case (idx)
         5'd0:    r = 24'sd823550;
         5'd1:    r = 24'sd486170;
         5'd2:    r = 24'sd256879;
         5'd3:    r = 24'sd130396;
         5'd4:    r = 24'sd65451;
         5'd5:    r = 24'sd32757;
         5'd6:    r = 24'sd16383;
         5'd7:    r = 24'sd8192;
         5'd8:    r = 24'sd4096;
         5'd9:    r = 24'sd2048;
         5'd10:   r = 24'sd1024;
         5'd11:   r = 24'sd512;
         5'd12:   r = 24'sd256;
         5'd13:   r = 24'sd128;
         5'd14:   r = 24'sd64;
         5'd15:   r = 24'sd32;
         5'd16:   r = 24'sd16;
         5'd17:   r = 24'sd8;
         5'd18:   r = 24'sd4;
         5'd19:   r = 24'sd2;
         5'd20:   r = 24'sd1;
         default: r = 24'sd0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/ggc_cordic.sv */
// ----------------------------------------------------------------------------
// ggc_cordic
// Vectoring CORDIC, one micro-rotation per cycle: angle and scaled magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module ggc_cordic (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ggc_pkg::cordic_req_type req,
   output ggc_pkg::cordic_rsp_type      rsp
);

   logic signed [ggc_pkg::VecW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ggc_pkg::AngW-1:0] z_ff, z_in;
   logic [ggc_pkg::IterW-1:0]       iter_ff, iter_in;
   logic                            busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      logic signed [ggc_pkg::VecW-1:0] xs, ys;
      logic signed [ggc_pkg::AngW-1:0] at;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      iter_in = iter_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      xs = x_ff >>> iter_ff;
      ys = y_ff >>> iter_ff;
      at = ggc_pkg::atan_q20(5'(iter_ff));
      if (req.start) begin
         iter_in = '0;
         busy_in = 1'b1;
         if (req.x < 0) begin
            // left half plane: turn by pi first
            z_in = (req.y >= 0) ? ggc_pkg::PiQ20 : -ggc_pkg::PiQ20;
            x_in = -req.x;
            y_in = -req.y;
         end else begin
            z_in = '0;
            x_in = req.x;
            y_in = req.y;
         end
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end else if (y_ff < 0) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end
         iter_in = iter_ff + 1'b1;
         if (iter_ff == ggc_pkg::IterW'(ggc_pkg::CordicSteps - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign rsp.done = done_ff;
   assign rsp.ang  = z_ff;
   assign rsp.mag  = x_ff;

endmodule

`default_nettype wire

/* hw/rtl/go_to_goal_controller_core.sv */
// ----------------------------------------------------------------------------
// go_to_goal_controller_core
// Proportional go-to-goal controller: goal events and odometry in, commands out.
// ----------------------------------------------------------------------------
// One item at a time. A goal event, or an odometry beat with no goal active,
// is answered with a registered result beat in the cycle after it is taken.
// For an odometry beat with a goal active, the result beat is offered only
// after the shared CORDIC has run once for the bearing and once for the yaw,
// one micro-rotation per cycle, and a single 18 x 33 multiplier has done the
// quaternion products, the distance scaling and both gains in turn. req_stall
// stays high from acceptance until the result beat is taken.
`default_nettype none

module go_to_goal_controller_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire logic               req_operation,
   input  wire logic signed [23:0] req_goal_x,
   input  wire logic signed [23:0] req_goal_y,
   input  wire logic signed [23:0] req_pos_x,
   input  wire logic signed [23:0] req_pos_y,
   input  wire logic signed [15:0] req_quat_x,
   input  wire logic signed [15:0] req_quat_y,
   input  wire logic signed [15:0] req_quat_z,
   input  wire logic signed [15:0] req_quat_w,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic [1:0]         rsp_kind,
   output      logic signed [23:0] rsp_linear_velocity,
   output      logic signed [15:0] rsp_angular_velocity,
   input  wire logic               csr_write_enable,
   input  wire logic [1:0]         csr_index,
   input  wire logic [22:0]        csr_write_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_BSTART, S_BWAIT, S_MLO, S_MHI, S_DIST, S_QWZ, S_QXY,
      S_QYY, S_QZZ, S_YSTART, S_YWAIT, S_ANG, S_LIN, S_OUT
   } state_type;

   state_type state_ff, state_in;

   logic [13:0] adb_ff, adb_in;
   logic [22:0] ddb_ff, ddb_in;
   logic [11:0] again_ff, again_in, lgain_ff, lgain_in;

   logic signed [23:0] tx_ff, tx_in, ty_ff, ty_in;
   logic               active_ff, active_in;

   logic signed [ggc_pkg::VecW-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [15:0] qx_ff, qx_in, qy_ff, qy_in, qz_ff, qz_in, qw_ff, qw_in;
   logic [32:0]        mag_ff, mag_in;
   logic signed [63:0] acc_ff, acc_in;
   logic [26:0]        dist_ff, dist_in;
   logic signed [15:0] bear_ff, bear_in;
   logic signed [16:0] err_ff, err_in;
   logic signed [15:0] angv_ff, angv_in;
   logic               aout_ff, aout_in;

   logic               rv_ff, rv_in;
   logic [1:0]         kind_ff, kind_in;
   logic signed [23:0] lin_ff, lin_in;
   logic signed [15:0] ang_ff, ang_in;

   logic signed [17:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [50:0] prod;

   ggc_pkg::cordic_req_type creq;
   ggc_pkg::cordic_rsp_type crsp;

   ggc_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .req   (creq),
      .rsp   (crsp)
   );

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MLO: begin
            mul_a = {2'b00, mag_ff[15:0]};
            mul_b = ggc_pkg::InvGainQ30;
         end
         S_MHI: begin
            mul_a = {1'b0, mag_ff[32:16]};
            mul_b = ggc_pkg::InvGainQ30;
         end
         S_QWZ: begin
            mul_a = 18'(qw_ff);
            mul_b = 33'(qz_ff);
         end
         S_QXY: begin
            mul_a = 18'(qx_ff);
            mul_b = 33'(qy_ff);
         end
         S_QYY: begin
            mul_a = 18'(qy_ff);
            mul_b = 33'(qy_ff);
         end
         S_QZZ: begin
            mul_a = 18'(qz_ff);
            mul_b = 33'(qz_ff);
         end
         S_ANG: begin
            mul_a = {6'b0, again_ff};
            mul_b = 33'(err_ff);
         end
         S_LIN: begin
            mul_a = {6'b0, lgain_ff};
            mul_b = {6'b0, dist_ff};
         end
         default: ;
      endcase
   end

   assign prod = mul_a * mul_b;

   always_comb begin
      logic signed [50:0] rnd;
      logic signed [23:0] yaw_sum;
      logic signed [15:0] yaw;
      logic signed [63:0] dsum;
      logic signed [16:0] aerr;
      logic               lout;
      state_in  = state_ff;
      adb_in    = adb_ff;
      ddb_in    = ddb_ff;
      again_in  = again_ff;
      lgain_in  = lgain_ff;
      tx_in     = tx_ff;
      ty_in     = ty_ff;
      active_in = active_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      qx_in     = qx_ff;
      qy_in     = qy_ff;
      qz_in     = qz_ff;
      qw_in     = qw_ff;
      mag_in    = mag_ff;
      acc_in    = acc_ff;
      dist_in   = dist_ff;
      bear_in   = bear_ff;
      err_in    = err_ff;
      angv_in   = angv_ff;
      aout_in   = aout_ff;
      rv_in     = rv_ff;
      kind_in   = kind_ff;
      lin_in    = lin_ff;
      ang_in    = ang_ff;
      creq.start = 1'b0;
      creq.x     = dx_ff;
      creq.y     = dy_ff;
      rnd     = (prod + 51'sd128) >>> 8;
      yaw_sum = crsp.ang + 24'sd128;
      yaw     = yaw_sum[23:8];
      dsum    = acc_ff + (64'sd1 <<< 35);
      aerr    = (err_ff < 0) ? -err_ff : err_ff;
      lout    = dist_ff >= {4'b0, ddb_ff};

      if (csr_write_enable) begin
         unique case (csr_index)
            ggc_pkg::CsrAngleDeadband:    adb_in   = csr_write_data[13:0];
            ggc_pkg::CsrDistanceDeadband: ddb_in   = csr_write_data;
            ggc_pkg::CsrAngleGain:        again_in = csr_write_data[11:0];
            ggc_pkg::CsrLinearGain:       lgain_in = csr_write_data[11:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_operation == ggc_pkg::OpGoal) begin
                  if (!active_ff) begin
                     tx_in     = req_goal_x;
                     ty_in     = req_goal_y;
                     active_in = 1'b1;
                  end
                  kind_in  = ggc_pkg::KindReset;
                  lin_in   = '0;
                  ang_in   = '0;
                  rv_in    = 1'b1;
                  state_in = S_OUT;
               end else if (!active_ff) begin
                  kind_in  = ggc_pkg::KindNone;
                  lin_in   = '0;
                  ang_in   = '0;
                  rv_in    = 1'b1;
                  state_in = S_OUT;
               end else begin
                  dx_in = ggc_pkg::VecW'(tx_ff - req_pos_x) <<< 6;
                  dy_in = ggc_pkg::VecW'(ty_ff - req_pos_y) <<< 6;
                  qx_in = req_quat_x;
                  qy_in = req_quat_y;
                  qz_in = req_quat_z;
                  qw_in = req_quat_w;
                  state_in = S_BSTART;
               end
            end
         end
         S_BSTART: begin
            creq.start = 1'b1;
            state_in   = S_BWAIT;
         end
         S_BWAIT: begin
            if (crsp.done) begin
               bear_in  = yaw;
               mag_in   = crsp.mag[32:0];
               state_in = S_MLO;
            end
         end
         S_MLO: begin
            acc_in   = 64'(prod);
            state_in = S_MHI;
         end
         S_MHI: begin
            acc_in   = acc_ff + (64'(prod) <<< 16);
            state_in = S_DIST;
         end
         S_DIST: begin
            dist_in  = dsum[62:36];
            state_in = S_QWZ;
         end
         S_QWZ: begin
            acc_in   = 64'(prod);
            state_in = S_QXY;
         end
         S_QXY: begin
            acc_in   = acc_ff + 64'(prod);
            state_in = S_QYY;
         end
         S_QYY: begin
            dy_in    = ggc_pkg::VecW'(acc_ff) <<< 1;
            acc_in   = 64'(prod);
            state_in = S_QZZ;
         end
         S_QZZ: begin
            acc_in   = acc_ff + 64'(prod);
            state_in = S_YSTART;
         end
         S_YSTART: begin
            creq.start = 1'b1;
            creq.x     = (ggc_pkg::VecW'(1) <<< 28) - (ggc_pkg::VecW'(acc_ff) <<< 1);
            state_in   = S_YWAIT;
         end
         S_YWAIT: begin
            if (crsp.done) begin
               err_in   = 17'(bear_ff) - 17'(yaw);
               state_in = S_ANG;
            end
         end
         S_ANG: begin
            aout_in = aerr >= {3'b0, adb_ff};
            if (aerr < {3'b0, adb_ff})
               angv_in = '0;
            else if (rnd > 51'sd32767)
               angv_in = 16'sh7FFF;
            else if (rnd < -51'sd32768)
               angv_in = -16'sh8000;
            else
               angv_in = rnd[15:0];
            state_in = S_LIN;
         end
         S_LIN: begin
            if (!lout)
               lin_in = '0;
            else if (rnd > 51'sd8388607)
               lin_in = 24'sh7FFFFF;
            else
               lin_in = rnd[23:0];
            ang_in = angv_ff;
            if (aout_ff || lout) begin
               kind_in = ggc_pkg::KindCmd;
            end else begin
               kind_in   = ggc_pkg::KindDone;
               active_in = 1'b0;
            end
            rv_in    = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               rv_in    = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         adb_ff    <= 14'd41;
         ddb_ff    <= 23'd2048;
         again_ff  <= 12'd256;
         lgain_ff  <= 12'd256;
         tx_ff     <= '0;
         ty_ff     <= '0;
         active_ff <= 1'b0;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         adb_ff    <= adb_in;
         ddb_ff    <= ddb_in;
         again_ff  <= again_in;
         lgain_ff  <= lgain_in;
         tx_ff     <= tx_in;
         ty_ff     <= ty_in;
         active_ff <= active_in;
         rv_ff     <= rv_in;
      end
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      qx_ff   <= qx_in;
      qy_ff   <= qy_in;
      qz_ff   <= qz_in;
      qw_ff   <= qw_in;
      mag_ff  <= mag_in;
      acc_ff  <= acc_in;
      dist_ff <= dist_in;
      bear_ff <= bear_in;
      err_ff  <= err_in;
      angv_ff <= angv_in;
      aout_ff <= aout_in;
      kind_ff <= kind_in;
      lin_ff  <= lin_in;
      ang_ff  <= ang_in;
   end

   assign req_stall            = (state_ff != S_IDLE);
   assign rsp_valid            = rv_ff;
   assign rsp_kind             = kind_ff;
   assign rsp_linear_velocity  = lin_ff;
   assign rsp_angular_velocity = ang_ff;

endmodule

`default_nettype wire

/* hw/rtl/ggc_checker.sv */
// ----------------------------------------------------------------------------
// ggc_checker
// Port-level checks of the go-to-goal controller, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ggc_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic [1:0]         rsp_kind,
   input wire logic signed [23:0] rsp_linear_velocity,
   input wire logic signed [15:0] rsp_angular_velocity
);

   // result beat held until taken
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid)

   // only one item in flight: no new beat while a result is pending
   `ASSERT_CLK_RST(a_one_in_flight, clock, reset, rsp_valid |-> req_stall)

   // an accepted beat keeps the input closed next cycle
   `ASSERT_CLK_RST(a_busy_after_accept, clock, reset, req_valid && !req_stall |=> req_stall)

   // non-command results carry zero velocities
   `ASSERT_CLK_RST(a_zero_vel, clock, reset, rsp_valid && (rsp_kind != ggc_pkg::KindCmd) |-> rsp_linear_velocity == 24'sd0 && rsp_angular_velocity == 16'sd0)

   // nothing is offered during reset
   `ASSERT_CLK(a_reset_quiet, clock, $past(reset) |-> !rsp_valid)

endmodule

bind go_to_goal_controller_core ggc_checker u_ggc_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_kind             (rsp_kind),
   .rsp_linear_velocity  (rsp_linear_velocity),
   .rsp_angular_velocity (rsp_angular_velocity)
);

`default_nettype wire

/* tb/go_to_goal_controller_checker.sv */
// ----------------------------------------------------------------------------
// go_to_goal_controller_checker
// Watches the request, result and register ports of the go-to-goal controller,
// predicts each result beat from its own copy of state and registers, and
// compares every accepted result beat field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module go_to_goal_controller_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_stall,
   input  wire logic               req_operation,
   input  wire logic signed [23:0] req_goal_x,
   input  wire logic signed [23:0] req_goal_y,
   input  wire logic signed [23:0] req_pos_x,
   input  wire logic signed [23:0] req_pos_y,
   input  wire logic signed [15:0] req_quat_x,
   input  wire logic signed [15:0] req_quat_y,
   input  wire logic signed [15:0] req_quat_z,
   input  wire logic signed [15:0] req_quat_w,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_stall,
   input  wire logic [1:0]         rsp_kind,
   input  wire logic signed [23:0] rsp_linear_velocity,
   input  wire logic signed [15:0] rsp_angular_velocity,
   input  wire logic               csr_write_enable,
   input  wire logic [1:0]         csr_index,
   input  wire logic [22:0]        csr_write_data,
   output int                      fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      ggc_pkg::kind_type  kind;
      logic signed [23:0] lin;
      logic signed [15:0] ang;
   } command_type;

   localparam longint PiAng   = 64'sd3294199;
   localparam longint InvGain = 64'sd652032874;

   longint arctan_steps [24] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383,
      8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0};

   logic [13:0]        ang_deadband;
   logic [22:0]        dist_deadband;
   logic [11:0]        ang_gain;
   logic [11:0]        lin_gain;
   logic signed [23:0] goal_x_q;
   logic signed [23:0] goal_y_q;
   logic               heading_to_goal;

   command_type pending_commands [$];
   int          mismatches = 0;

   initial fail_count = 0;

   function automatic longint round_off(input longint v, input int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   // vectoring rotation: angle Q.20, magnitude carries the rotation gain
   function automatic void vector_angle(input longint xi, input longint yi,
                                        output longint ang, output longint mag);
      longint x, y, z, xs, ys;
      x = xi;
      y = yi;
      z = 0;
      if (x < 0) begin
         z = (y >= 0) ? PiAng : -PiAng;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < ggc_pkg::CordicSteps; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys;
            y = y - xs;
            z = z + arctan_steps[i];
         end else if (y < 0) begin
            x = x - ys;
            y = y + xs;
            z = z - arctan_steps[i];
         end
      end
      ang = z;
      mag = x;
   endfunction

   function automatic command_type steer(input logic signed [23:0] px,
                                         input logic signed [23:0] py,
                                         input logic signed [15:0] qx,
                                         input logic signed [15:0] qy,
                                         input logic signed [15:0] qz,
                                         input logic signed [15:0] qw);
      command_type c;
      longint dx, dy, yv, xv, a, m, bearing, yaw, err, distance, aerr, v;
      logic ang_out, lin_out;
      dx = (longint'(goal_x_q) - longint'(px)) * 64;
      dy = (longint'(goal_y_q) - longint'(py)) * 64;
      yv = 2 * (longint'(qw) * qz + longint'(qx) * qy);
      xv = (64'sd1 <<< 28) - 2 * (longint'(qy) * qy + longint'(qz) * qz);
      vector_angle(dx, dy, a, m);
      bearing = round_off(a, 8);
      distance = round_off(m * InvGain, 36);
      vector_angle(xv, yv, a, m);
      yaw = round_off(a, 8);
      err = bearing - yaw;
      aerr = (err < 0) ? -err : err;
      ang_out = aerr >= longint'(ang_deadband);
      lin_out = distance >= longint'(dist_deadband);
      c.ang = '0;
      c.lin = '0;
      if (ang_out) begin
         v = round_off(longint'(ang_gain) * err, 8);
         v = (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
         c.ang = v[15:0];
      end
      if (lin_out) begin
         v = round_off(longint'(lin_gain) * distance, 8);
         v = (v > 8388607) ? 8388607 : ((v < -8388608) ? -8388608 : v);
         c.lin = v[23:0];
      end
      c.kind = (ang_out || lin_out) ? ggc_pkg::KindCmd : ggc_pkg::KindDone;
      return c;
   endfunction

   always @(posedge clock) begin
      command_type c;
      if (reset) begin
         ang_deadband    <= 14'd41;
         dist_deadband   <= 23'd2048;
         ang_gain        <= 12'd256;
         lin_gain        <= 12'd256;
         goal_x_q        <= '0;
         goal_y_q        <= '0;
         heading_to_goal <= 1'b0;
         pending_commands.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               ggc_pkg::CsrAngleDeadband:    ang_deadband  <= csr_write_data[13:0];
               ggc_pkg::CsrDistanceDeadband: dist_deadband <= csr_write_data;
               ggc_pkg::CsrAngleGain:        ang_gain      <= csr_write_data[11:0];
               ggc_pkg::CsrLinearGain:       lin_gain      <= csr_write_data[11:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            c.kind = ggc_pkg::KindNone;
            c.lin = '0;
            c.ang = '0;
            if (req_operation == ggc_pkg::OpGoal) begin
               if (!heading_to_goal) begin
                  goal_x_q        <= req_goal_x;
                  goal_y_q        <= req_goal_y;
                  heading_to_goal <= 1'b1;
               end
               c.kind = ggc_pkg::KindReset;
            end else if (heading_to_goal) begin
               c = steer(req_pos_x, req_pos_y, req_quat_x, req_quat_y, req_quat_z,
                         req_quat_w);
               if (c.kind == ggc_pkg::KindDone) heading_to_goal <= 1'b0;
            end
            pending_commands.push_back(c);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_commands.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result beat: kind %0d lin %0d ang %0d",
                           rsp_kind, rsp_linear_velocity, rsp_angular_velocity);
            end else begin
               c = pending_commands.pop_front();
               if (rsp_kind !== c.kind || rsp_linear_velocity !== c.lin ||
                   rsp_angular_velocity !== c.ang) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: expected kind %0d lin %0d ang %0d, ",
                               "got kind %0d lin %0d ang %0d"},
                              c.kind, c.lin, c.ang, rsp_kind, rsp_linear_velocity,
                              rsp_angular_velocity);
               end
            end
         end
      end
      // leftover expectations count once the run is over
      fail_count = mismatches + int'(pending_commands.size());
   end

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the go-to-goal controller: directed goal and
// odometry beats, then random approach sequences under four handshake
// pressure phases, each with its own register setting.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IdleLimit = 4000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_operation = ggc_pkg::OpSample;
   logic signed [23:0] req_goal_x = '0;
   logic signed [23:0] req_goal_y = '0;
   logic signed [23:0] req_pos_x = '0;
   logic signed [23:0] req_pos_y = '0;
   logic signed [15:0] req_quat_x = '0;
   logic signed [15:0] req_quat_y = '0;
   logic signed [15:0] req_quat_z = '0;
   logic signed [15:0] req_quat_w = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_kind;
   logic signed [23:0] rsp_linear_velocity;
   logic signed [15:0] rsp_angular_velocity;
   logic               csr_write_enable = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [22:0]        csr_write_data = '0;
   int                 fail_count;

   int sent_beats = 0;
   int taken_beats = 0;
   int idle_cycles = 0;
   int send_gap_pct = 0;
   int stall_pct = 0;
   logic signed [23:0] last_goal_x = '0;
   logic signed [23:0] last_goal_y = '0;

   always #6 clock = ~clock;

   go_to_goal_controller_core dut (.*);

   go_to_goal_controller_checker checker_i (.*);

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
      if (rsp_valid && !rsp_stall) taken_beats++;
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
         $display("testbench failed");
         $finish;
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [22:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_beat(input logic op, input logic signed [23:0] gx,
                            input logic signed [23:0] gy,
                            input logic signed [23:0] px,
                            input logic signed [23:0] py,
                            input logic signed [15:0] qx, input logic signed [15:0] qy,
                            input logic signed [15:0] qz, input logic signed [15:0] qw);
      req_valid     <= 1'b1;
      req_operation <= op;
      req_goal_x    <= gx;
      req_goal_y    <= gy;
      req_pos_x     <= px;
      req_pos_y     <= py;
      req_quat_x    <= qx;
      req_quat_y    <= qy;
      req_quat_z    <= qz;
      req_quat_w    <= qw;
      if (op == ggc_pkg::OpGoal) begin
         last_goal_x = gx;
         last_goal_y = gy;
      end
      do @(posedge clock); while (req_stall);
      sent_beats++;
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
   endtask

   function automatic logic signed [15:0] rand_quat();
      return 16'($signed($urandom_range(32768)) - 16384);
   endfunction

   task automatic wait_quiet();
      // drop valid right away so the last beat is not taken twice
      req_valid <= 1'b0;
      while (taken_beats != sent_beats) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic random_beat();
      int pick;
      logic signed [23:0] ox, oy;
      pick = $urandom_range(99);
      if (pick < 12) begin
         send_beat(ggc_pkg::OpGoal, 24'($urandom), 24'($urandom), 24'($urandom),
                   24'($urandom), rand_quat(), rand_quat(), rand_quat(), rand_quat());
      end else if (pick < 22) begin
         send_beat(ggc_pkg::OpSample, 24'($urandom), 24'($urandom), 24'($urandom),
                   24'($urandom), rand_quat(), rand_quat(), rand_quat(), rand_quat());
      end else if (pick < 55) begin
         // approach along +x with heading zero: ends in done once inside deadband
         ox = 24'($urandom_range(4096));
         send_beat(ggc_pkg::OpSample, 24'($urandom), 24'($urandom), last_goal_x - ox,
                   last_goal_y, 16'sd0, 16'sd0, 16'sd0, 16'sd16384);
      end else begin
         ox = 24'($signed($urandom_range(65536)) - 32768);
         oy = 24'($signed($urandom_range(65536)) - 32768);
         send_beat(ggc_pkg::OpSample, 24'($urandom), 24'($urandom), last_goal_x + ox,
                   last_goal_y + oy, 16'($signed($urandom_range(800)) - 400),
                   16'($signed($urandom_range(800)) - 400), rand_quat(), rand_quat());
      end
   endtask

   initial begin
      int gaps [4]   = '{0, 65, 0, 28};
      int stalls [4] = '{0, 0, 65, 28};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int p = 0; p < 4; p++) begin
         wait_quiet();
         send_gap_pct = gaps[p];
         stall_pct    = stalls[p];
         case (p)
            0: begin
               csr_write(ggc_pkg::CsrAngleDeadband, 23'd41);
               csr_write(ggc_pkg::CsrDistanceDeadband, 23'd2048);
               csr_write(ggc_pkg::CsrAngleGain, 23'd256);
               csr_write(ggc_pkg::CsrLinearGain, 23'd256);
            end
            1: begin
               // all ones, narrower registers keep their low bits
               csr_write(ggc_pkg::CsrAngleDeadband, 23'h7FFFFF);
               csr_write(ggc_pkg::CsrDistanceDeadband, 23'h7FFFFF);
               csr_write(ggc_pkg::CsrAngleGain, 23'h7FFFFF);
               csr_write(ggc_pkg::CsrLinearGain, 23'h7FFFFF);
            end
            2: begin
               csr_write(ggc_pkg::CsrAngleDeadband, 23'd0);
               csr_write(ggc_pkg::CsrDistanceDeadband, 23'd0);
               csr_write(ggc_pkg::CsrAngleGain, 23'd0);
               csr_write(ggc_pkg::CsrLinearGain, 23'd0);
            end
            default: begin
               csr_write(ggc_pkg::CsrAngleDeadband, 23'($urandom_range(12868)));
               csr_write(ggc_pkg::CsrDistanceDeadband, 23'($urandom_range(16384)));
               csr_write(ggc_pkg::CsrAngleGain, 23'($urandom_range(4095)));
               csr_write(ggc_pkg::CsrLinearGain, 23'($urandom_range(4095)));
            end
         endcase
         if (p == 0) begin
            // sample with no goal, then goal at the positive extreme
            send_beat(ggc_pkg::OpSample, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000,
                      16'sd16384, -16'sd16384, 16'sd16384, -16'sd16384);
            send_beat(ggc_pkg::OpGoal, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh800000,
                      -16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384);
            // goal while active is ignored
            send_beat(ggc_pkg::OpGoal, 24'sh800000, 24'sh800000, 24'sd0, 24'sd0,
                      16'sd0, 16'sd0, 16'sd0, 16'sd0);
            send_beat(ggc_pkg::OpSample, 24'sd0, 24'sd0, 24'sh800000, 24'sh800000,
                      16'sd0, 16'sd0, 16'sd0, 16'sd0);
            send_beat(ggc_pkg::OpSample, 24'sd0, 24'sd0, 24'sh800000, 24'sh7FFFFF,
                      16'sd16384, 16'sd0, 16'sd0, 16'sd0);
            send_beat(ggc_pkg::OpSample, 24'sd0, 24'sd0, 24'sh7FFFF0, 24'sh7FFFFF,
                      16'sd0, 16'sd0, 16'sd16384, 16'sd0);
            send_beat(ggc_pkg::OpSample, 24'sd0, 24'sd0, 24'sh7FFFFF, 24'sh800000,
                      16'sd0, 16'sd0, -16'sd16384, 16'sd11585);
            // robot on goal, zero quaternion: done
            send_beat(ggc_pkg::OpSample, 24'sd0, 24'sd0, 24'sh7FFFFF, 24'sh7FFFFF,
                      16'sd0, 16'sd0, 16'sd0, 16'sd0);
            send_beat(ggc_pkg::OpSample, 24'sd5, 24'sd5, 24'sd1, 24'sd1,
                      16'sd0, 16'sd0, 16'sd0, 16'sd16384);
            send_beat(ggc_pkg::OpGoal, 24'sh800000, 24'sh800000, 24'sd0, 24'sd0,
                      16'sd0, 16'sd0, 16'sd0, 16'sd0);
            send_beat(ggc_pkg::OpSample, 24'sd0, 24'sd0, 24'sh7FFFFF, 24'sh7FFFFF,
                      16'sd0, 16'sd0, 16'sd11585, -16'sd11585);
            send_beat(ggc_pkg::OpSample, 24'sd0, 24'sd0, 24'sh800000 + 24'sd100,
                      24'sh800000, 16'sd0, 16'sd0, 16'sd0, 16'sd16384);
            send_beat(ggc_pkg::OpSample, 24'sd0, 24'sd0, 24'sh800000, 24'sh800000,
                      16'sd0, 16'sd0, 16'sd0, 16'sd16384);
            send_beat(ggc_pkg::OpGoal, -24'sd4096, 24'sd4096, 24'sd0, 24'sd0,
                      16'sd0, 16'sd0, 16'sd0, 16'sd0);
            send_beat(ggc_pkg::OpSample, 24'sd0, 24'sd0, 24'sd0, 24'sd0,
                      16'sd100, -16'sd200, 16'sd300, 16'sd16000);
         end
         for (int n = 0; n < 135; n++) random_beat();
      end
      wait_quiet();
      repeat (60) @(posedge clock);
      if (fail_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule

`default_nettype wire
